@@ sv/swmmm_pkg.sv @@
// ----------------------------------------------------------------------------
// swmmm_pkg - shared constants for the sliding window mean/min/max block
// Field widths of the stream beats and the default window depth.
// ----------------------------------------------------------------------------
package swmmm_pkg;

  localparam int SAMPLE_W             = 7;   // brightness sample, percent
  localparam int FILLED_W             = 5;   // reported fill count
  localparam int MEAN_W               = 15;  // mean, 8 fractional bits
  localparam int FRAC_BITS            = 8;
  localparam int SAMPLE_MAX           = 127; // largest code of a sample
  localparam int DEFAULT_WINDOW_DEPTH = 20;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

endpackage

@@ sv/swmmm_div.sv @@
// ----------------------------------------------------------------------------
// swmmm_div - bit-serial restoring divider
// One quotient bit per cycle; the dividend shifts out of the quotient
// register MSB first while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module swmmm_div #(
  parameter int DW = 20,  // dividend / quotient width
  parameter int VW = 5    // divisor width
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [DW-1:0]    quo;
  logic [VW:0]      trial;
  logic             ge;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

@@ sv/sliding_window_mean_min_max.sv @@
// ----------------------------------------------------------------------------
// sliding_window_mean_min_max - moving window of samples with mean/min/max
// Ring of the last WINDOW_DEPTH samples; one result beat per sample beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one brightness sample per beat. m_* returns one result per
//   sample: the sample, the fill count, floor(total*256/count) and the
//   largest and smallest filled entries.
//   One sample is processed at a time. After a sample beat the block
//   updates the ring and the running total in UPDATE, then in RUN runs the
//   bit-serial divider alongside a scan of the filled entries through the
//   ring's single read port, then loads the output register in DONE and
//   returns to IDLE to take the next sample beat. While the receiver keeps
//   up, the longer of divider and scan sets the rate; the scan is the
//   longer one once the window holds TOTAL_W+8 entries or more.
//   The result sits in an output register, so the next sample is taken while
//   it waits; a stalled receiver holds off the following result, then s_tready.
//   Reset (rst, synchronous) empties the window: fill count, write slot and
//   total go to zero. Ring contents are not cleared; only filled entries
//   are ever used.
// ----------------------------------------------------------------------------
module sliding_window_mean_min_max
  import swmmm_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] sample, [7] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [6:0] sample_echo,
                                            // [11:7] filled_entries,
                                            // [26:12] mean_q8,
                                            // [33:27] window_max,
                                            // [40:34] window_min,
                                            // [47:41] zero
);

  localparam int AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW      = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
  localparam int DW      = TOTAL_W + FRAC_BITS;

  typedef enum logic [1:0] {IDLE, UPDATE, RUN, DONE} state_t;

  state_t              state;
  logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       write_slot;
  logic [CW-1:0]       fill_count;
  logic [TOTAL_W-1:0]  running_total;
  logic [SAMPLE_W-1:0] sample_q;

  logic [CW-1:0]       issue_cnt;   // scan reads issued so far
  logic                rd_vld;      // rd_data holds a scan entry
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;

  logic                full;
  logic [TOTAL_W-1:0]  total_next;
  logic [CW-1:0]       fill_next;
  logic                scan_issue;
  logic                div_start;
  logic                div_busy;
  logic [DW-1:0]       quotient;

  assign s_tready = (state == IDLE);
  assign full     = (fill_count == CW'(WINDOW_DEPTH));

  // the replaced entry leaves the total only once the ring is full
  assign total_next = running_total
                      - (full ? TOTAL_W'(rd_data) : '0)
                      + TOTAL_W'(sample_q);
  assign fill_next  = full ? fill_count : fill_count + 1'b1;

  assign scan_issue = (state == RUN) && (issue_cnt != fill_count);
  assign div_start  = (state == UPDATE);

  // IDLE reads the slot about to be overwritten; RUN walks the entries
  assign rd_addr = (state == IDLE) ? write_slot : issue_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
    if (state == UPDATE) begin
      ring[write_slot] <= sample_q;
    end
  end

  swmmm_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({total_next, FRAC_BITS'(0)}),
    .divisor  (fill_next),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      write_slot    <= '0;
      fill_count    <= '0;
      running_total <= '0;
      issue_cnt     <= '0;
      rd_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // DONE reloads the output register itself when the beat leaves
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            sample_q <= s_tdata[SAMPLE_W-1:0];
            state    <= UPDATE;
          end
        end
        UPDATE: begin
          running_total <= total_next;
          fill_count    <= fill_next;
          write_slot    <= (write_slot == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                  : write_slot + 1'b1;
          issue_cnt     <= '0;
          rd_vld        <= 1'b0;
          hi            <= '0;
          lo            <= SAMPLE_W'(SAMPLE_MAX);
          state         <= RUN;
        end
        RUN: begin
          rd_vld <= scan_issue;
          if (scan_issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_vld) begin
            if (rd_data > hi) hi <= rd_data;
            if (rd_data < lo) lo <= rd_data;
          end
          if (!scan_issue && !rd_vld && !div_busy) begin
            state <= DONE;
          end
        end
        DONE: begin
          // wait for the output register to drain
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(OUT_TDATA_W - 41){1'b0}}, lo, hi, quotient[MEAN_W-1:0],
                         FILLED_W'(fill_count), sample_q};
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stream testbench for sliding_window_mean_min_max
// A queue-fed driver pushes brightness samples, and a scoreboard checks each
// result beat against a cycle-free window predictor. Both sides idle in
// random bursts, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import swmmm_pkg::*;

  localparam int DEPTH          = DEFAULT_WINDOW_DEPTH;
  localparam int RANDOM_ITEMS   = 650;
  localparam int CALM_TAIL      = 60;    // last beats sent with no idling
  localparam int LONG_HOLD      = 300;   // receiver stall that fills the block
  localparam int HOLD_AFTER     = 150;   // results seen before that stall
  localparam int DRAIN_CYCLES   = 64;    // settle time after the last result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

  // Result beat laid out as on m_tdata, lowest field last.
  typedef struct packed {
    logic [6:0]           pad;
    logic [SAMPLE_W-1:0]  window_min;
    logic [SAMPLE_W-1:0]  window_max;
    logic [MEAN_W-1:0]    mean_q8;
    logic [FILLED_W-1:0]  filled_entries;
    logic [SAMPLE_W-1:0]  sample_echo;
  } window_result_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  sliding_window_mean_min_max i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  logic [SAMPLE_W-1:0] pending_samples[$];
  window_result_t      expected_results[$];
  int                  error_count  = 0;
  int                  results_seen = 0;
  int                  samples_sent = 0;

  // Shadow of the window state.
  logic [SAMPLE_W-1:0] ring_shadow[DEPTH];
  int unsigned         slot_shadow  = 0;
  int unsigned         fill_shadow  = 0;
  int unsigned         total_shadow = 0;

  // Idling stops once the tail of the stimulus is reached.
  function automatic bit idle_ok();
    return pending_samples.size() > CALM_TAIL;
  endfunction

  // Inserts one sample and returns the statistics the block must report.
  function automatic window_result_t window_update(logic [SAMPLE_W-1:0] smp);
    window_result_t r;
    int unsigned    hi;
    int unsigned    lo;
    // oldest entry drops out of the total only once the ring is full
    if (fill_shadow >= DEPTH) total_shadow -= ring_shadow[slot_shadow];
    ring_shadow[slot_shadow] = smp;
    total_shadow += smp;
    slot_shadow = (slot_shadow + 1) % DEPTH;
    if (fill_shadow < DEPTH) fill_shadow++;
    hi = 0;
    lo = SAMPLE_MAX;
    for (int i = 0; i < fill_shadow; i++) begin
      if (ring_shadow[i] > hi) hi = ring_shadow[i];
      if (ring_shadow[i] < lo) lo = ring_shadow[i];
    end
    r                = '0;
    r.sample_echo    = smp;
    r.filled_entries = FILLED_W'(fill_shadow);
    r.mean_q8        = MEAN_W'((total_shadow << FRAC_BITS) / fill_shadow);
    r.window_max     = SAMPLE_W'(hi);
    r.window_min     = SAMPLE_W'(lo);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
               $time, name, results_seen, exp_v, act_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued samples, predicts on every accepted beat.
  // tx_mode picks how often bursts of idle cycles appear; it is redrawn every
  // 50 beats so that calm stretches alternate with choppy ones.
  // --------------------------------------------------------------------------
  int tx_gap  = 0;
  int tx_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(window_update(s_tdata[SAMPLE_W-1:0]));
        samples_sent++;
        if (samples_sent % 50 == 0) tx_mode = $urandom_range(0, 2);
      end
      // a new beat may go out only when the current one is gone
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'(pending_samples.pop_front());
          if (idle_ok() && tx_mode != 0 && $urandom_range(0, 6 - 2 * tx_mode) == 0)
            tx_gap = $urandom_range(1, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready bursts, plus one long hold-off after HOLD_AFTER
  // results so the output register fills and s_tready drops.
  // --------------------------------------------------------------------------
  int rx_hold      = 0;
  int rx_mode      = 0;
  bit long_hold_on = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!long_hold_on && results_seen >= HOLD_AFTER) begin
      long_hold_on = 1'b1;
      rx_hold      = LONG_HOLD - 1;
      m_tready    <= 1'b0;
    end else if (idle_ok() && rx_mode != 0 && $urandom_range(0, 6 - 2 * rx_mode) == 0) begin
      rx_hold   = $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    window_result_t act;
    window_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      act = window_result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("sample_echo", 32'(exp_r.sample_echo), 32'(act.sample_echo));
        check_field("filled_entries", 32'(exp_r.filled_entries),
                    32'(act.filled_entries));
        check_field("mean_q8", 32'(exp_r.mean_q8), 32'(act.mean_q8));
        check_field("window_max", 32'(exp_r.window_max), 32'(act.window_max));
        check_field("window_min", 32'(exp_r.window_min), 32'(act.window_min));
      end
      results_seen++;
      if (results_seen % 50 == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  // Watchdog: any beat on either side restarts the count.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int           kind;
    int           run_len;
    int           level;
    int           step;
    int unsigned  queued;

    // Directed: extremes, out-of-range values, alternating bit patterns,
    // then fill the window and overwrite the oldest entries past the wrap.
    pending_samples = '{7'd0, 7'd127, 7'd100, 7'd101, 7'd85, 7'd42, 7'd1, 7'd126};
    repeat (DEPTH - 8) pending_samples.push_back(7'd50);
    pending_samples.push_back(7'd127);  // replaces the zero: min rises
    pending_samples.push_back(7'd0);    // replaces the 127: max held by new entry
    pending_samples.push_back(7'd127);
    pending_samples.push_back(7'd0);
    pending_samples.push_back(7'd3);

    // Random runs: mostly nominal readings, some over-range, flat stretches
    // long enough to flush the whole window, and ramps.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(1, 30);
      case (kind)
        6, 7: begin
          repeat (run_len) pending_samples.push_back(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        end
        8: begin
          run_len = $urandom_range(DEPTH, DEPTH + 10);
          case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 100;
            2: level = SAMPLE_MAX;
            default: level = $urandom_range(0, SAMPLE_MAX);
          endcase
          repeat (run_len) pending_samples.push_back(SAMPLE_W'(level));
        end
        9: begin
          level = $urandom_range(0, SAMPLE_MAX);
          step  = $urandom_range(0, 1) ? 3 : -3;
          repeat (run_len) begin
            pending_samples.push_back(SAMPLE_W'(level));
            level = (level + step < 0 || level + step > SAMPLE_MAX) ? level : level + step;
          end
        end
        default: begin
          repeat (run_len) pending_samples.push_back(SAMPLE_W'($urandom_range(0, 100)));
        end
      endcase
      queued += run_len;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
